// ----- hw/rtl/kpms_pkg.sv -----
// ----------------------------------------------------------------------------
// kpms_pkg
// Widths and the stored pair layout shared by the sorter, its channels and
// its storage.
// ----------------------------------------------------------------------------
package kpms_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int PAIR_W    = KEY_W + PAYLOAD_W;

   typedef struct packed {
      logic signed [KEY_W-1:0]     key;
      logic signed [PAYLOAD_W-1:0] payload;
   } pair_type;

endpackage

// ----- hw/rtl/kpms_if.sv -----
// ----------------------------------------------------------------------------
// kpms channels
// Valid/ready channels of the sorter: pair beats in, sorted beats out.
// ----------------------------------------------------------------------------
interface kpms_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [kpms_pkg::KEY_W-1:0]      key;
   logic signed [kpms_pkg::PAYLOAD_W-1:0]  payload;
   logic                                   is_last;

   modport source (output valid, output key, output payload, output is_last, input ready);
   modport sink   (input valid, input key, input payload, input is_last, output ready);
endinterface

interface kpms_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [kpms_pkg::KEY_W-1:0]      sorted_key;
   logic signed [kpms_pkg::PAYLOAD_W-1:0]  sorted_payload;
   logic                                   last_out;
   logic                                   overflow;

   modport source (output valid, output sorted_key, output sorted_payload,
                   output last_out, output overflow, input ready);
   modport sink   (input valid, input sorted_key, input sorted_payload,
                   input last_out, input overflow, output ready);
endinterface

// ----- hw/rtl/kpms_ram.sv -----
// ----------------------------------------------------------------------------
// kpms_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module kpms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WIDTH-1:0]           rd_data_a,
   output logic [WIDTH-1:0]           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- hw/rtl/key_payload_merge_sorter.sv -----
// ----------------------------------------------------------------------------
// key_payload_merge_sorter
// Stable ascending sort of signed key/payload pairs, bottom-up merge sort.
// ----------------------------------------------------------------------------
// Pairs are taken one beat per cycle into RAM A of a ping-pong pair of RAMs
// until the beat flagged is_last; beats beyond DEPTH are dropped and reported
// through overflow on every result of that set. Sorting then runs
// ceil(log2(n)) merge passes through one shared key comparator: each pass
// opens in S_PASS, each run pair in S_SETUP, and each merged entry goes
// through a RAM read (S_RD) and then a compare and write (S_CMP). Each
// result beat is read (S_OUT_RD), registered (S_OUT_WAIT) and held
// (S_OUT_HOLD) until the sink takes it.
// Equal keys leave in load order. No input beat is taken from
// is_last until the last result beat of the set is delivered.
module key_payload_merge_sorter #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   kpms_req_if.sink    req_if,
   kpms_rsp_if.source  rsp_if
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 2;

   typedef enum logic [2:0] {
      S_LOAD, S_PASS, S_SETUP, S_RD, S_CMP, S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   logic          src_ff, src_in;
   logic [CW:0]   w_ff, w_in;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] li_ff, li_in;
   logic [CW-1:0] ri_ff, ri_in;
   logic [CW-1:0] lend_ff, lend_in;
   logic [CW-1:0] rend_ff, rend_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] o_ff, o_in;
   logic          rsp_valid_ff, rsp_valid_in;
   kpms_pkg::pair_type rsp_pair_ff, rsp_pair_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic req_fire, rsp_fire, full, take_right;
   logic [SW-1:0] s_plus_w, s_plus_2w, n_ext;
   logic [CW-1:0] lend_new, rend_new, k_next, o_next;
   kpms_pkg::pair_type left_pair, right_pair, take_pair, load_pair;

   logic                          a_we, b_we;
   logic [AW-1:0]                 a_waddr, rd_addr_a, rd_addr_b;
   logic [kpms_pkg::PAIR_W-1:0]   a_wdata;
   logic [kpms_pkg::PAIR_W-1:0]   a_rd_a, a_rd_b, b_rd_a, b_rd_b;

   assign req_if.ready = (state_ff == S_LOAD);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;
   assign full         = (fill_ff == CW'(DEPTH));

   assign load_pair.key     = req_if.key;
   assign load_pair.payload = req_if.payload;

   // merge compare: right head wins on a strictly smaller key or once the left run is spent
   assign left_pair  = src_ff ? b_rd_a : a_rd_a;
   assign right_pair = src_ff ? b_rd_b : a_rd_b;
   assign take_right = (li_ff == lend_ff) ||
                       ((ri_ff != rend_ff) && (right_pair.key < left_pair.key));
   assign take_pair  = take_right ? right_pair : left_pair;

   assign n_ext     = SW'(fill_ff);
   assign s_plus_w  = SW'(s_ff) + SW'(w_ff);
   assign s_plus_2w = SW'(s_ff) + SW'({w_ff, 1'b0});
   assign lend_new  = (s_plus_w < n_ext) ? s_plus_w[CW-1:0] : fill_ff;
   assign rend_new  = (s_plus_2w < n_ext) ? s_plus_2w[CW-1:0] : fill_ff;
   assign k_next    = k_ff + CW'(1);
   assign o_next    = o_ff + CW'(1);

   assign a_we      = (req_fire && !full) || ((state_ff == S_CMP) && src_ff);
   assign b_we      = (state_ff == S_CMP) && !src_ff;
   assign a_waddr   = (state_ff == S_LOAD) ? fill_ff[AW-1:0] : k_ff[AW-1:0];
   assign a_wdata   = (state_ff == S_LOAD) ? load_pair : take_pair;
   assign rd_addr_a = (state_ff == S_OUT_RD) ? o_ff[AW-1:0] : li_ff[AW-1:0];
   assign rd_addr_b = ri_ff[AW-1:0];

   kpms_ram #(.WIDTH(kpms_pkg::PAIR_W), .DEPTH(DEPTH)) u_ram_a (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (a_waddr),
      .wr_data   (a_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (a_rd_a),
      .rd_data_b (a_rd_b)
   );

   kpms_ram #(.WIDTH(kpms_pkg::PAIR_W), .DEPTH(DEPTH)) u_ram_b (
      .clock     (clock),
      .wr_en     (b_we),
      .wr_addr   (k_ff[AW-1:0]),
      .wr_data   (take_pair),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (b_rd_a),
      .rd_data_b (b_rd_b)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      w_in         = w_ff;
      s_in         = s_ff;
      li_in        = li_ff;
      ri_in        = ri_ff;
      lend_in      = lend_ff;
      rend_in      = rend_ff;
      k_in         = k_ff;
      o_in         = o_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pair_in  = rsp_pair_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
               if (req_if.is_last) begin
                  w_in     = (CW + 1)'(1);
                  src_in   = 1'b0;
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            if (w_ff >= (CW + 1)'(fill_ff)) begin
               o_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               s_in     = '0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            li_in    = s_ff;
            ri_in    = lend_new;
            lend_in  = lend_new;
            rend_in  = rend_new;
            k_in     = s_ff;
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            k_in = k_next;
            if (take_right) begin
               ri_in = ri_ff + CW'(1);
            end else begin
               li_in = li_ff + CW'(1);
            end
            if (k_next == rend_ff) begin
               s_in = rend_ff;
               if (rend_ff == fill_ff) begin
                  w_in     = {w_ff[CW-1:0], 1'b0};
                  src_in   = ~src_ff;
                  state_in = S_PASS;
               end else begin
                  state_in = S_SETUP;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            rsp_pair_in  = left_pair;
            rsp_last_in  = (o_next == fill_ff);
            rsp_ovf_in   = ovf_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               o_in         = o_next;
               if (o_next == fill_ff) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      src_ff      <= src_in;
      w_ff        <= w_in;
      s_ff        <= s_in;
      li_ff       <= li_in;
      ri_ff       <= ri_in;
      lend_ff     <= lend_in;
      rend_ff     <= rend_in;
      k_ff        <= k_in;
      o_ff        <= o_in;
      rsp_pair_ff <= rsp_pair_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.sorted_key     = rsp_pair_ff.key;
   assign rsp_if.sorted_payload = rsp_pair_ff.payload;
   assign rsp_if.last_out       = rsp_last_ff;
   assign rsp_if.overflow       = rsp_ovf_ff;

   // result beats only leave from the holding state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (state_ff == S_OUT_HOLD))
      else $error("result beat outside holding state");

   // store count never passes its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");

   // merge write position stays inside the current run pair
   a_merge_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> ((k_ff < rend_ff) && (k_ff >= s_ff)))
      else $error("merge position outside run pair");

   // closing beat empties the store and reopens loading
   a_set_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_if.last_out) |=> ((state_ff == S_LOAD) && (fill_ff == '0) && !ovf_ff))
      else $error("set not closed after final beat");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_payload_merge_sorter: pair beats go in through
// the request channel, and every sorted beat that comes out is compared field
// by field against an in-bench stable sort of the same set or, for single-pair
// sets at the signed extremes, zero and minus one, a hand-written answer; a
// short table of these and other directed sets comes first. Random sets follow:
// mostly small, a few full, and some that overflow the store, each dropping its
// closing beat. Both channels stall at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH      = 64;
   localparam int ITEMS      = 370;
   localparam int QUIET_MAX  = 20000;
   localparam int TAIL       = 100;

   localparam logic signed [kpms_pkg::KEY_W-1:0] K_MAX = 32'sh7fffffff;
   localparam logic signed [kpms_pkg::KEY_W-1:0] K_MIN = 32'sh80000000;
   localparam logic signed [kpms_pkg::KEY_W-1:0] K_ONE = 32'sh00000001;
   localparam logic signed [kpms_pkg::KEY_W-1:0] K_NEG = 32'shffffffff;
   localparam logic signed [kpms_pkg::KEY_W-1:0] K_ZERO = 32'sh00000000;

   typedef struct packed {
      logic signed [kpms_pkg::KEY_W-1:0]     key;
      logic signed [kpms_pkg::PAYLOAD_W-1:0] payload;
      logic                                  last_out;
      logic                                  overflow;
   } sorted_beat_type;

   typedef struct packed {
      logic signed [kpms_pkg::KEY_W-1:0]     key;
      logic signed [kpms_pkg::PAYLOAD_W-1:0] payload;
      logic                                  is_last;
      logic                                  typed;
      logic signed [kpms_pkg::KEY_W-1:0]     exp_key;
      logic signed [kpms_pkg::PAYLOAD_W-1:0] exp_payload;
      logic                                  exp_ovf;
   } dir_row_type;

   localparam int DIR_N = 21;

   // key, payload, is_last, typed, expected key, expected payload, expected overflow
   localparam dir_row_type DIR_ROWS [0:DIR_N-1] = '{
      '{K_MAX,  K_MIN,  1'b1, 1'b1, K_MAX,  K_MIN,  1'b0},
      '{K_MIN,  K_MAX,  1'b1, 1'b1, K_MIN,  K_MAX,  1'b0},
      '{K_ZERO, K_ZERO, 1'b1, 1'b1, K_ZERO, K_ZERO, 1'b0},
      '{K_NEG,  K_NEG,  1'b1, 1'b1, K_NEG,  K_NEG,  1'b0},
      '{32'sd5,  32'sd1,  1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{-32'sd3, 32'sd2,  1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd5,  32'sd3,  1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_MIN,   32'sd4,  1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_MAX,   32'sd5,  1'b1, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd7,  32'sd10, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd7,  32'sd11, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd7,  32'sd12, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd7,  32'sd13, 1'b1, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{32'sd2,  32'sd20, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_ONE,   32'sd21, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_ZERO,  32'sd22, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_NEG,   32'sd23, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{-32'sd2, 32'sd24, 1'b1, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_MAX,   32'sd30, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_MAX,   32'sd31, 1'b0, 1'b0, K_ZERO, K_ZERO, 1'b0},
      '{K_MIN,   32'sd32, 1'b1, 1'b0, K_ZERO, K_ZERO, 1'b0}
   };

   logic clock;
   logic reset;

   kpms_req_if req_ch ();
   kpms_rsp_if rsp_ch ();

   key_payload_merge_sorter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   kpms_pkg::pair_type held_pairs [DEPTH];
   int                 held_count;
   bit                 held_dropped;
   sorted_beat_type    sorted_due_q [$];
   int                 mismatch_count;
   int                 quiet_cycles;
   bit                 tx_up;
   bit                 tx_calm;
   bit                 rx_calm;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   // stable insertion sort of the held set once its closing beat is taken
   task automatic absorb_pair(input kpms_pkg::pair_type p, input logic closes,
                              input bit typed, input sorted_beat_type typed_beat);
      kpms_pkg::pair_type work [DEPTH];
      kpms_pkg::pair_type cur;
      sorted_beat_type    beat;
      int                 j;
      if (held_count < DEPTH) begin
         held_pairs[held_count] = p;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (closes) begin
         work = held_pairs;
         for (int i = 1; i < held_count; i++) begin
            cur = work[i];
            j = i;
            while (j > 0 && $signed(cur.key) < $signed(work[j-1].key)) begin
               work[j] = work[j-1];
               j--;
            end
            work[j] = cur;
         end
         if (typed) begin
            sorted_due_q.push_back(typed_beat);
         end else begin
            for (int k = 0; k < held_count; k++) begin
               beat.key      = work[k].key;
               beat.payload  = work[k].payload;
               beat.last_out = (k == held_count - 1);
               beat.overflow = held_dropped;
               sorted_due_q.push_back(beat);
            end
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic push_pair(input kpms_pkg::pair_type p, input logic closes,
                            input bit typed, input sorted_beat_type typed_beat);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         if (tx_up) req_ch.valid <= 1'b0;
         tx_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.key     <= p.key;
      req_ch.payload <= p.payload;
      req_ch.is_last <= closes;
      tx_up = 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      absorb_pair(p, closes, typed, typed_beat);
   endtask

   task automatic hold_until_drained();
      if (tx_up) req_ch.valid <= 1'b0;
      tx_up = 1'b0;
      while (sorted_due_q.size() != 0) @(posedge clock);
   endtask

   // sender
   initial begin
      kpms_pkg::pair_type p;
      sorted_beat_type    beat;
      int                 sent;
      int                 set_idx;
      int                 set_len;
      int                 pick;
      int                 style;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.key     <= '0;
      req_ch.payload <= '0;
      req_ch.is_last <= 1'b0;
      held_count     = 0;
      held_dropped   = 1'b0;
      mismatch_count = 0;
      tx_up          = 1'b0;
      tx_calm        = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_N; r++) begin
         p.key         = DIR_ROWS[r].key;
         p.payload     = DIR_ROWS[r].payload;
         beat.key      = DIR_ROWS[r].exp_key;
         beat.payload  = DIR_ROWS[r].exp_payload;
         beat.last_out = 1'b1;
         beat.overflow = DIR_ROWS[r].exp_ovf;
         push_pair(p, DIR_ROWS[r].is_last, DIR_ROWS[r].typed, beat);
      end
      hold_until_drained();

      beat    = '0;
      sent    = 0;
      set_idx = 0;
      while (sent < ITEMS) begin
         pick = $urandom_range(0, 99);
         if (set_idx == 0) set_len = DEPTH + 1;
         else if (set_idx == 1) set_len = DEPTH + 6;
         else if (pick < 3) set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
         else if (pick < 8) set_len = DEPTH;
         else if (pick < 20) set_len = $urandom_range(9, 40);
         else set_len = $urandom_range(1, 8);
         style   = $urandom_range(0, 2);
         tx_calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_len; i++) begin
            case (style)
               0: p.key = $urandom;
               1: p.key = $urandom_range(0, 6) - 3;
               default: begin
                  case ($urandom_range(0, 3))
                     0: p.key = K_MIN;
                     1: p.key = K_MAX;
                     2: p.key = K_ZERO;
                     default: p.key = K_NEG;
                  endcase
               end
            endcase
            p.payload = $urandom;
            push_pair(p, (i == set_len - 1), 1'b0, beat);
         end
         sent += set_len;
         set_idx++;
         if ($urandom_range(0, 7) == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("key_payload_merge_sorter verification clean");
      end else begin
         $display("key_payload_merge_sorter verification failed");
      end
      $finish;
   end

   // receiver
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      rx_calm = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
         gap = rx_calm ? 0 : $urandom_range(0, 18);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   always @(posedge clock) begin
      sorted_beat_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (sorted_due_q.size() == 0) begin
            flag_mismatch($sformatf("beat with nothing due, key %0d payload %0d",
                                    rsp_ch.sorted_key, rsp_ch.sorted_payload));
         end else begin
            due = sorted_due_q.pop_front();
            if (rsp_ch.sorted_key !== due.key)
               flag_mismatch($sformatf("sorted_key %0d, want %0d",
                                       rsp_ch.sorted_key, due.key));
            if (rsp_ch.sorted_payload !== due.payload)
               flag_mismatch($sformatf("sorted_payload %0d, want %0d (key %0d)",
                                       rsp_ch.sorted_payload, due.payload, due.key));
            if (rsp_ch.last_out !== due.last_out)
               flag_mismatch($sformatf("last_out %b, want %b (key %0d)",
                                       rsp_ch.last_out, due.last_out, due.key));
            if (rsp_ch.overflow !== due.overflow)
               flag_mismatch($sformatf("overflow %b, want %b (key %0d)",
                                       rsp_ch.overflow, due.overflow, due.key));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("key_payload_merge_sorter verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
hw/rtl/kpms_pkg.sv
hw/rtl/kpms_if.sv
hw/rtl/kpms_ram.sv
hw/rtl/key_payload_merge_sorter.sv
dv/tb.sv
